// File: sv/bcsm_pkg.sv
// shared types, constants and the control store of the beat clip sample mixer
// no dependencies; imported by every module of the block
`default_nettype none

package bcsm_pkg;

  localparam int CLIP_COUNT   = 16;
  localparam int SAMPLE_DEPTH = 4096;

  localparam int CLIP_W = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
  localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int RI_W   = $clog2(SAMPLE_DEPTH + 1);

  // field widths of the ports
  localparam int POS_W      = 17;
  localparam int LEN_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int SMP_W      = 16;
  localparam int CIDX_W     = 4;
  localparam int SADDR_W    = 12;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // sample times gain, then headroom for every clip
  localparam int PROD_W = SMP_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + CLIP_W + 1;

  localparam int UPC_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 2'd0,
    CMD_WRITE_CLIP   = 2'd1,
    CMD_WRITE_SAMPLE = 2'd2,
    CMD_RESET_POS    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAT_PERIOD = 2'd0,
    CFG_DOWNBEAT_LEN = 2'd1,
    CFG_SUBDIV_LEN  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COND_ALWAYS     = 2'd0,
    COND_TICK_START = 2'd1,
    COND_CLIP_LAST  = 2'd2,
    COND_OUT_BUSY   = 2'd3
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE    = 3'd0;
  localparam upc_t UPC_ISSUE   = 3'd1;
  localparam upc_t UPC_DRAIN_A = 3'd2;
  localparam upc_t UPC_DRAIN_B = 3'd3;
  localparam upc_t UPC_ROUND   = 3'd4;

  // one control word: datapath strobes, branch condition, two successors
  typedef struct packed {
    logic  idle;
    logic  issue;
    logic  finish;
    cond_e cond;
    upc_t  jump_hit;
    upc_t  jump_miss;
  } ucw_t;

  typedef struct packed {
    logic              idle;
    logic              issue;
    logic              finish;
    logic [CLIP_W-1:0] clip;
  } ctrl_t;

  typedef struct packed {
    logic tick_start;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic              valid;
    logic              src;
    logic [ADDR_W-1:0] addr;
    logic [GAIN_W-1:0] gain;
  } rd_req_t;

  function automatic ucw_t ucode_rom(input upc_t upc);
    ucw_t w;
    unique case (upc)
      UPC_IDLE:    w = '{idle: 1'b1, issue: 1'b0, finish: 1'b0, cond: COND_TICK_START,
                         jump_hit: UPC_ISSUE, jump_miss: UPC_IDLE};
      UPC_ISSUE:   w = '{idle: 1'b0, issue: 1'b1, finish: 1'b0, cond: COND_CLIP_LAST,
                         jump_hit: UPC_DRAIN_A, jump_miss: UPC_ISSUE};
      UPC_DRAIN_A: w = '{idle: 1'b0, issue: 1'b0, finish: 1'b0, cond: COND_ALWAYS,
                         jump_hit: UPC_DRAIN_B, jump_miss: UPC_DRAIN_B};
      UPC_DRAIN_B: w = '{idle: 1'b0, issue: 1'b0, finish: 1'b0, cond: COND_ALWAYS,
                         jump_hit: UPC_ROUND, jump_miss: UPC_ROUND};
      UPC_ROUND:   w = '{idle: 1'b0, issue: 1'b0, finish: 1'b1, cond: COND_OUT_BUSY,
                         jump_hit: UPC_ROUND, jump_miss: UPC_IDLE};
      default:     w = '{idle: 1'b0, issue: 1'b0, finish: 1'b0, cond: COND_ALWAYS,
                         jump_hit: UPC_IDLE, jump_miss: UPC_IDLE};
    endcase
    return w;
  endfunction

  // a length beyond the store counts as the whole store
  function automatic logic [RI_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [31:0] ext;
    ext = 32'(len);
    if (ext > 32'(SAMPLE_DEPTH)) begin
      return RI_W'(SAMPLE_DEPTH);
    end
    return ext[RI_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/beat_clip_sample_mixer_top.sv
// top level of the beat clip sample mixer: ports, registers, beat position, output stage
// depends on bcsm_pkg, bcsm_sequencer, bcsm_clip_table, bcsm_sample_store, bcsm_mac
`default_nettype none

// A beat metronome that mixes sample clips. Each tick request yields one output
// frame; clip writes, sample writes and position resets yield nothing. A tick
// is run by a small microprogram that visits the clips in index order, one clip
// per cycle through the clip table and the shared read port of the sample
// memories, followed by two drain steps to empty the multiply and accumulate
// pipeline and one rounding step. The block takes no new request until that
// rounding step is done, and the rounding step waits while a previous frame is
// still held in the output register. The input stall is high for the whole of a
// tick. Sample memories have no reset; reading a word that was never written
// gives an undefined frame. Configuration is to be written through its own port
// only when the block is idle; the block itself does not enforce it. The port is
// always ready, so a write is taken in the cycle it is offered.

module beat_clip_sample_mixer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bcsm_pkg::CMD_W-1:0]          cmd_i,
  input  logic [bcsm_pkg::CIDX_W-1:0]         clip_index_i,
  input  logic [bcsm_pkg::POS_W-1:0]          clip_start_frame_i,
  input  logic [bcsm_pkg::GAIN_W-1:0]         clip_volume_i,
  input  logic                                clip_uses_downbeat_i,
  input  logic                                clip_active_i,
  input  logic                                sample_select_i,
  input  logic [bcsm_pkg::SADDR_W-1:0]        sample_address_i,
  input  logic signed [bcsm_pkg::SMP_W-1:0]   sample_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bcsm_pkg::SMP_W-1:0]   mixed_sample_o,
  output logic                                clipped_o,
  // configuration write port
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bcsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcsm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bcsm_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  rd_req_t req;
  cmd_e    cmd;
  logic    in_acc;
  logic    tick_start;

  // configuration registers
  logic [POS_W-1:0] period_q;
  logic [LEN_W-1:0] len_db_q;
  logic [LEN_W-1:0] len_sd_q;

  logic [POS_W-1:0] pos_q;

  // output register
  logic                    out_valid_q;
  logic signed [SMP_W-1:0] mixed_q;
  logic                    clipped_q;
  logic                    out_busy;

  logic signed [SMP_W-1:0] db_word;
  logic signed [SMP_W-1:0] sd_word;
  logic signed [SMP_W-1:0] mac_mixed;
  logic                    mac_clipped;

  // requests are taken only while the sequencer sits in its idle step
  assign in_stall_o = !ctrl.idle;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(cmd_i);
  assign tick_start = in_acc && (cmd == CMD_TICK);

  // a frame waits in the output register while the far side stalls
  assign out_busy = out_valid_q && out_stall_i;

  assign status.tick_start = tick_start;
  assign status.out_busy   = out_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= POS_W'(48000);
      len_db_q <= '0;
      len_sd_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BEAT_PERIOD:  period_q <= cfg_data_i[POS_W-1:0];
        CFG_DOWNBEAT_LEN: len_db_q <= cfg_data_i[LEN_W-1:0];
        CFG_SUBDIV_LEN:   len_sd_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // beat position: wraps as a tick starts, cleared by a position reset, steps on as the frame is registered for output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      priority if (tick_start) begin
        if (pos_q >= period_q) begin
          pos_q <= '0;
        end
      end else if (in_acc && (cmd == CMD_RESET_POS)) begin
        pos_q <= '0;
      end else if (ctrl.finish) begin
        pos_q <= pos_q + POS_W'(1);
      end else begin
        pos_q <= pos_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      mixed_q   <= mac_mixed;
      clipped_q <= mac_clipped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign clipped_o      = clipped_q;

  bcsm_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  bcsm_clip_table u_clips (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .wr_i        (in_acc && (cmd == CMD_WRITE_CLIP)),
    .wr_index_i  (clip_index_i),
    .wr_start_i  (clip_start_frame_i),
    .wr_gain_i   (clip_volume_i),
    .wr_src_i    (clip_uses_downbeat_i),
    .wr_active_i (clip_active_i),
    .pos_i       (pos_q),
    .len_db_i    (clamp_len(len_db_q)),
    .len_sd_i    (clamp_len(len_sd_q)),
    .req_o       (req)
  );

  bcsm_sample_store u_store (
    .clk_i     (clk_i),
    .wr_i      (in_acc && (cmd == CMD_WRITE_SAMPLE)),
    .wr_sel_i  (sample_select_i),
    .wr_addr_i (sample_address_i),
    .wr_data_i (sample_value_i),
    .rd_addr_i (req.addr),
    .db_o      (db_word),
    .sd_o      (sd_word)
  );

  bcsm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (tick_start),
    .req_i     (req),
    .db_i      (db_word),
    .sd_i      (sd_word),
    .mixed_o   (mac_mixed),
    .clipped_o (mac_clipped)
  );

endmodule

`default_nettype wire

// File: sv/bcsm_sequencer.sv
// microcoded sequencer: step counter, control store lookup, clip loop counter
// depends on bcsm_pkg
`default_nettype none

module bcsm_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcsm_pkg::status_t status_i,
  output bcsm_pkg::ctrl_t   ctrl_o
);
  import bcsm_pkg::*;

  upc_t              upc_q, upc_d;
  logic [CLIP_W-1:0] clip_q, clip_d;
  ucw_t              ucw;
  logic              cond_met;

  always_comb ucw = ucode_rom(upc_q);

  always_comb begin
    unique case (ucw.cond)
      COND_ALWAYS:     cond_met = 1'b1;
      COND_TICK_START: cond_met = status_i.tick_start;
      COND_CLIP_LAST:  cond_met = (clip_q == CLIP_W'(CLIP_COUNT - 1));
      COND_OUT_BUSY:   cond_met = status_i.out_busy;
    endcase
  end

  always_comb begin
    upc_d = cond_met ? ucw.jump_hit : ucw.jump_miss;
    priority if (ucw.idle) begin
      clip_d = '0;
    end else if (ucw.issue) begin
      clip_d = clip_q + CLIP_W'(1);
    end else begin
      clip_d = clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= UPC_IDLE;
      clip_q <= '0;
    end else begin
      upc_q  <= upc_d;
      clip_q <= clip_d;
    end
  end

  assign ctrl_o.idle   = ucw.idle;
  assign ctrl_o.issue  = ucw.issue;
  assign ctrl_o.finish = ucw.finish && !status_i.out_busy;
  assign ctrl_o.clip   = clip_q;

endmodule

`default_nettype wire

// File: sv/bcsm_clip_table.sv
// clip table: start, gain, source, enable, play flag and read index per clip
// depends on bcsm_pkg; visited one clip per cycle under sequencer control
`default_nettype none

module bcsm_clip_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcsm_pkg::ctrl_t             ctrl_i,
  input  logic                        wr_i,
  input  logic [bcsm_pkg::CIDX_W-1:0] wr_index_i,
  input  logic [bcsm_pkg::POS_W-1:0]  wr_start_i,
  input  logic [bcsm_pkg::GAIN_W-1:0] wr_gain_i,
  input  logic                        wr_src_i,
  input  logic                        wr_active_i,
  input  logic [bcsm_pkg::POS_W-1:0]  pos_i,
  input  logic [bcsm_pkg::RI_W-1:0]   len_db_i,
  input  logic [bcsm_pkg::RI_W-1:0]   len_sd_i,
  output bcsm_pkg::rd_req_t           req_o
);
  import bcsm_pkg::*;

  logic [POS_W-1:0]  start_q [CLIP_COUNT];
  logic [GAIN_W-1:0] gain_q  [CLIP_COUNT];
  logic              src_q   [CLIP_COUNT];
  logic              en_q    [CLIP_COUNT];
  logic              play_q  [CLIP_COUNT];
  logic [RI_W-1:0]   ri_q    [CLIP_COUNT];

  logic [31:0]       wi_ext;
  logic              wr_ok;
  logic [CLIP_W-1:0] wi;
  logic [CLIP_W-1:0] c;
  logic [RI_W-1:0]   cur_len;
  logic              starting;
  logic              live;
  logic              fits;

  assign wi_ext = 32'(wr_index_i);
  assign wr_ok  = wi_ext < 32'(CLIP_COUNT);
  assign wi     = wi_ext[CLIP_W-1:0];
  assign c      = ctrl_i.clip;

  always_comb begin
    cur_len  = src_q[c] ? len_db_i : len_sd_i;
    starting = en_q[c] && !play_q[c] && (start_q[c] == pos_i);
    live     = play_q[c] || starting;
    fits     = ri_q[c] < cur_len;
    req_o.valid = ctrl_i.issue && live && fits;
    req_o.src   = src_q[c];
    req_o.addr  = ri_q[c][ADDR_W-1:0];
    req_o.gain  = gain_q[c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLIP_COUNT; i++) begin
        start_q[i] <= '0;
        gain_q[i]  <= '0;
        src_q[i]   <= 1'b0;
        en_q[i]    <= 1'b0;
        play_q[i]  <= 1'b0;
        ri_q[i]    <= '0;
      end
    end else begin
      // a rewrite leaves a play under way running
      if (wr_i && wr_ok) begin
        start_q[wi] <= wr_start_i;
        gain_q[wi]  <= wr_gain_i;
        src_q[wi]   <= wr_src_i;
        en_q[wi]    <= wr_active_i;
      end
      if (ctrl_i.issue && live) begin
        if (fits) begin
          play_q[c] <= 1'b1;
          ri_q[c]   <= ri_q[c] + RI_W'(1);
        end else begin
          play_q[c] <= 1'b0;
          ri_q[c]   <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/bcsm_sample_store.sv
// downbeat and subdivision sample memories, one write port, registered read
// depends on bcsm_pkg
`default_nettype none

module bcsm_sample_store (
  input  logic                                clk_i,
  input  logic                                wr_i,
  input  logic                                wr_sel_i,
  input  logic [bcsm_pkg::SADDR_W-1:0]        wr_addr_i,
  input  logic signed [bcsm_pkg::SMP_W-1:0]   wr_data_i,
  input  logic [bcsm_pkg::ADDR_W-1:0]         rd_addr_i,
  output logic signed [bcsm_pkg::SMP_W-1:0]   db_o,
  output logic signed [bcsm_pkg::SMP_W-1:0]   sd_o
);
  import bcsm_pkg::*;

  logic signed [SMP_W-1:0] db_mem [SAMPLE_DEPTH];
  logic signed [SMP_W-1:0] sd_mem [SAMPLE_DEPTH];

  logic [31:0]       wa_ext;
  logic              wr_ok;
  logic [ADDR_W-1:0] wa;

  assign wa_ext = 32'(wr_addr_i);
  assign wr_ok  = wa_ext < 32'(SAMPLE_DEPTH);
  assign wa     = wa_ext[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i && wr_ok && wr_sel_i) begin
      db_mem[wa] <= wr_data_i;
    end
    if (wr_i && wr_ok && !wr_sel_i) begin
      sd_mem[wa] <= wr_data_i;
    end
    db_o <= db_mem[rd_addr_i];
    sd_o <= sd_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// File: sv/bcsm_mac.sv
// multiply and accumulate pipeline, rounding to q1.15 and saturation
// depends on bcsm_pkg; fed by the clip table and the sample store
`default_nettype none

module bcsm_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  bcsm_pkg::rd_req_t                 req_i,
  input  logic signed [bcsm_pkg::SMP_W-1:0] db_i,
  input  logic signed [bcsm_pkg::SMP_W-1:0] sd_i,
  output logic signed [bcsm_pkg::SMP_W-1:0] mixed_o,
  output logic                              clipped_o
);
  import bcsm_pkg::*;

  logic                     s1_valid_q;
  logic                     s1_src_q;
  logic [GAIN_W-1:0]        s1_gain_q;
  logic                     s2_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SMP_W-1:0]  word;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  q;

  always_comb begin
    word   = s1_src_q ? db_i : sd_i;
    prod_d = word * $signed({1'b0, s1_gain_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
      if (clear_i) begin
        acc_q <= '0;
      end else if (s2_valid_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_src_q  <= req_i.src;
    s1_gain_q <= req_i.gain;
    prod_q    <= prod_d;
  end

  // round half up, then floor by 2^15
  always_comb begin
    sum = acc_q + ACC_W'(32'sd16384);
    q   = sum >>> 15;
    priority if (q > ACC_W'(32'sd32767)) begin
      mixed_o   = 16'sh7fff;
      clipped_o = 1'b1;
    end else if (q < ACC_W'(-32'sd32768)) begin
      mixed_o   = 16'sh8000;
      clipped_o = 1'b1;
    end else begin
      mixed_o   = q[SMP_W-1:0];
      clipped_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking bench for the beat clip sample mixer: directed and random request streams
// with an in-order predictor of every output frame. Depends on bcsm_pkg and
// beat_clip_sample_mixer_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcsm_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  // covers a whole tick from acceptance back to the idle step, plus a little margin
  localparam int SETTLE_CYCLES = CLIP_COUNT + 12;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS = 200;
  // a play reads one word per tick, so no read index gets past this prefix
  localparam int LOAD_WORDS = 256;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int START_SPAN = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct {
    cmd_e                     op;
    logic [CIDX_W-1:0]        clip;
    logic [POS_W-1:0]         start;
    logic [GAIN_W-1:0]        gain;
    logic                     downbeat;
    logic                     enable;
    logic                     to_downbeat;
    logic [SADDR_W-1:0]       addr;
    logic signed [SMP_W-1:0]  word;
  } request_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    clipped;
  } frame_t;

  // clock, reset and every input known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  cmd_e                     cmd = CMD_TICK;
  logic [CIDX_W-1:0]        clip_index = '0;
  logic [POS_W-1:0]         clip_start_frame = '0;
  logic [GAIN_W-1:0]        clip_volume = '0;
  logic                     clip_uses_downbeat = 1'b0;
  logic                     clip_active = 1'b0;
  logic                     sample_select = 1'b0;
  logic [SADDR_W-1:0]       sample_address = '0;
  logic signed [SMP_W-1:0]  sample_value = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SMP_W-1:0]  mixed_sample;
  logic                     clipped;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // idling of both sides in percent of cycles, and the receiver hold-off
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int frames_seen = 0;
  int frame_mismatches = 0;

  // predicted state of the mixer
  logic [POS_W-1:0]         mdl_period;
  logic [POS_W-1:0]         mdl_position;
  logic [LEN_W-1:0]         mdl_down_len;
  logic [LEN_W-1:0]         mdl_sub_len;
  logic [POS_W-1:0]         mdl_start [CLIP_COUNT];
  logic [GAIN_W-1:0]        mdl_gain [CLIP_COUNT];
  bit                       mdl_downbeat [CLIP_COUNT];
  bit                       mdl_enabled [CLIP_COUNT];
  bit                       mdl_playing [CLIP_COUNT];
  int unsigned              mdl_read_idx [CLIP_COUNT];
  logic signed [SMP_W-1:0]  downbeat_words [SAMPLE_DEPTH];
  logic signed [SMP_W-1:0]  subdiv_words [SAMPLE_DEPTH];

  // frames still owed by the block, oldest first
  frame_t expected_frames[$];

  beat_clip_sample_mixer_top uut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .cmd_i                (cmd),
    .clip_index_i         (clip_index),
    .clip_start_frame_i   (clip_start_frame),
    .clip_volume_i        (clip_volume),
    .clip_uses_downbeat_i (clip_uses_downbeat),
    .clip_active_i        (clip_active),
    .sample_select_i      (sample_select),
    .sample_address_i     (sample_address),
    .sample_value_i       (sample_value),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .mixed_sample_o       (mixed_sample),
    .clipped_o            (clipped),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  always #2 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // every accepted frame against the oldest prediction
  always @(posedge clk) begin : check_frames
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        if (frame_mismatches < REPORT_LIMIT) begin
          $display("frame %0d arrived with none expected: sample %0d clipped %0b",
                   frames_seen, mixed_sample, clipped);
        end
        frame_mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (want.sample !== mixed_sample || want.clipped !== clipped) begin
          if (frame_mismatches < REPORT_LIMIT) begin
            $display("frame %0d: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                     frames_seen, want.sample, want.clipped, mixed_sample, clipped);
          end
          frame_mismatches++;
        end
      end
      frames_seen++;
    end
  end

  function automatic void reset_mixer_model();
    mdl_period = POS_W'(48000);
    mdl_position = '0;
    mdl_down_len = '0;
    mdl_sub_len = '0;
    for (int c = 0; c < CLIP_COUNT; c++) begin
      mdl_start[c] = '0;
      mdl_gain[c] = '0;
      mdl_downbeat[c] = 1'b0;
      mdl_enabled[c] = 1'b0;
      mdl_playing[c] = 1'b0;
      mdl_read_idx[c] = 0;
    end
    for (int a = 0; a < SAMPLE_DEPTH; a++) begin
      downbeat_words[a] = '0;
      subdiv_words[a] = '0;
    end
  endfunction

  // one tick: wrap, start and play clips in index order, round and saturate the sum
  function automatic frame_t mix_one_frame();
    longint acc;
    longint rounded;
    int unsigned limit;
    logic signed [SMP_W-1:0] word;
    frame_t f;
    acc = 0;
    if (mdl_position >= mdl_period) mdl_position = '0;
    for (int c = 0; c < CLIP_COUNT; c++) begin
      if (mdl_enabled[c] && !mdl_playing[c] && mdl_start[c] == mdl_position) begin
        mdl_playing[c] = 1'b1;
      end
      if (mdl_playing[c]) begin
        limit = mdl_downbeat[c] ? mdl_down_len : mdl_sub_len;
        if (limit > SAMPLE_DEPTH) limit = SAMPLE_DEPTH;
        if (mdl_read_idx[c] < limit) begin
          word = mdl_downbeat[c] ? downbeat_words[mdl_read_idx[c]]
                                 : subdiv_words[mdl_read_idx[c]];
          acc += longint'(word) * longint'(mdl_gain[c]);
          mdl_read_idx[c]++;
        end else begin
          // run past its length: silent this tick, stops and rewinds
          mdl_playing[c] = 1'b0;
          mdl_read_idx[c] = 0;
        end
      end
    end
    rounded = (acc + 64'sd16384) >>> 15;
    f.clipped = 1'b0;
    if (rounded > 32767) begin
      f.sample = 16'sh7fff;
      f.clipped = 1'b1;
    end else if (rounded < -32768) begin
      f.sample = 16'sh8000;
      f.clipped = 1'b1;
    end else begin
      f.sample = rounded[SMP_W-1:0];
    end
    mdl_position = mdl_position + 1'b1;
    return f;
  endfunction

  function automatic void track_request(input request_t r);
    case (r.op)
      CMD_WRITE_CLIP: begin
        // playing flag and read index are left alone
        mdl_start[r.clip] = r.start;
        mdl_gain[r.clip] = r.gain;
        mdl_downbeat[r.clip] = r.downbeat;
        mdl_enabled[r.clip] = r.enable;
      end
      CMD_WRITE_SAMPLE: begin
        if (r.to_downbeat) downbeat_words[r.addr] = r.word;
        else subdiv_words[r.addr] = r.word;
      end
      CMD_RESET_POS: mdl_position = '0;
      default: expected_frames.push_back(mix_one_frame());
    endcase
  endfunction

  // every field random, so unused fields also toggle
  function automatic request_t noise_request();
    request_t r;
    r.op = cmd_e'($urandom_range(3));
    r.clip = CIDX_W'($urandom);
    r.start = POS_W'($urandom);
    r.gain = GAIN_W'($urandom);
    r.downbeat = 1'($urandom);
    r.enable = 1'($urandom);
    r.to_downbeat = 1'($urandom);
    r.addr = SADDR_W'($urandom);
    r.word = SMP_W'($urandom);
    return r;
  endfunction

  function automatic request_t tick_request();
    request_t r;
    r = noise_request();
    r.op = CMD_TICK;
    return r;
  endfunction

  function automatic request_t position_reset_request();
    request_t r;
    r = noise_request();
    r.op = CMD_RESET_POS;
    return r;
  endfunction

  function automatic request_t clip_request(input int idx, input int start, input int gain,
                                            input bit downbeat, input bit enable);
    request_t r;
    r = noise_request();
    r.op = CMD_WRITE_CLIP;
    r.clip = CIDX_W'(idx);
    r.start = POS_W'(start);
    r.gain = GAIN_W'(gain);
    r.downbeat = downbeat;
    r.enable = enable;
    return r;
  endfunction

  function automatic request_t sample_request(input bit to_downbeat, input int addr,
                                              input logic signed [SMP_W-1:0] word);
    request_t r;
    r = noise_request();
    r.op = CMD_WRITE_SAMPLE;
    r.to_downbeat = to_downbeat;
    r.addr = SADDR_W'(addr);
    r.word = word;
    return r;
  endfunction

  // mostly ticks over a programmed clip table, with start frames that the position reaches
  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    int unsigned span;
    r = noise_request();
    pick = $urandom_range(99);
    if (pick < 68) begin
      r.op = CMD_TICK;
    end else if (pick < 84) begin
      r.op = CMD_WRITE_CLIP;
      span = (mdl_period > START_SPAN) ? START_SPAN : mdl_period;
      if ($urandom_range(9) < 8) r.start = (span == 0) ? '0 : POS_W'($urandom_range(span - 1));
      case ($urandom_range(5))
        0: r.gain = GAIN_W'(32768);
        1: r.gain = '1;
        2, 3: r.gain = GAIN_W'($urandom_range(32768));
        default: ;
      endcase
      r.enable = ($urandom_range(3) != 0);
    end else if (pick < 95) begin
      r.op = CMD_WRITE_SAMPLE;
    end else begin
      r.op = CMD_RESET_POS;
    end
    return r;
  endfunction

  // offer one request after a random gap and wait until the block takes it
  task automatic send_request(input request_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= r.op;
    clip_index <= r.clip;
    clip_start_frame <= r.start;
    clip_volume <= r.gain;
    clip_uses_downbeat <= r.downbeat;
    clip_active <= r.enable;
    sample_select <= r.to_downbeat;
    sample_address <= r.addr;
    sample_value <= r.word;
    do @(posedge clk); while (in_stall);
    track_request(r);
  endtask

  // stop offering, collect every owed frame, then let the last tick settle
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle; the unused index goes first and must be ignored
  task automatic program_registers(input logic [CFG_DATA_W-1:0] period,
                                   input logic [CFG_DATA_W-1:0] down_len,
                                   input logic [CFG_DATA_W-1:0] sub_len);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_NO_REG, CFG_BEAT_PERIOD, CFG_DOWNBEAT_LEN, CFG_SUBDIV_LEN};
    val = '{CFG_DATA_W'($urandom), period, down_len, sub_len};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        CFG_BEAT_PERIOD:  mdl_period = val[k];
        CFG_DOWNBEAT_LEN: mdl_down_len = val[k][LEN_W-1:0];
        CFG_SUBDIV_LEN:   mdl_sub_len = val[k][LEN_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // the low words of both stores, so that no play ever reads a blank word: before the
  // long-length phase lengths stay small, and that phase has too few ticks to get past
  task automatic load_sample_stores();
    for (int a = 0; a < LOAD_WORDS; a++) begin
      send_request(sample_request(1'b1, a, SMP_W'($urandom)));
      send_request(sample_request(1'b0, a, SMP_W'($urandom)));
    end
    drain_frames();
  endtask

  // all clips disabled after reset: silent frames
  task automatic test_ticks_after_reset();
    send_request(tick_request());
    send_request(tick_request());
    drain_frames();
  endtask

  // extreme words and gains, gain above one, a zero gain and a disabled clip
  task automatic test_saturation_extremes();
    program_registers(17'd4, 17'd4, 17'd2);
    send_request(sample_request(1'b1, 0, 16'sh7fff));
    send_request(sample_request(1'b1, 1, 16'sh8000));
    send_request(sample_request(1'b0, 0, 16'sh8000));
    send_request(sample_request(1'b0, 1, 16'sd1));
    send_request(clip_request(0, 0, 65535, 1'b1, 1'b1));
    send_request(clip_request(CLIP_COUNT - 1, 0, 32768, 1'b1, 1'b1));
    send_request(clip_request(1, 1, 0, 1'b0, 1'b1));
    send_request(clip_request(2, 0, 1, 1'b0, 1'b0));
    send_request(position_reset_request());
    // wraps at period four, then the downbeat clips run out
    repeat (6) send_request(tick_request());
    drain_frames();
  endtask

  // a clip rewritten mid-play finishes with its new gain and store
  task automatic test_rewrite_while_playing();
    send_request(position_reset_request());
    send_request(tick_request());
    send_request(clip_request(0, 5, 1, 1'b0, 1'b0));
    repeat (3) send_request(tick_request());
    send_request(position_reset_request());
    send_request(tick_request());
    drain_frames();
  endtask

  task automatic test_random_phase(input logic [CFG_DATA_W-1:0] period,
                                   input logic [CFG_DATA_W-1:0] down_len,
                                   input logic [CFG_DATA_W-1:0] sub_len);
    program_registers(period, down_len, sub_len);
    repeat (PHASE_ITEMS) send_request(random_request());
    drain_frames();
  endtask

  // receiver holds off while ticks keep coming, so the held frame backs up the input
  task automatic test_output_backpressure();
    hold_left = HOLD_OFF_CYCLES;
    repeat (12) send_request(tick_request());
    drain_frames();
  endtask

  initial begin
    reset_mixer_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender rarely idle, receiver often stalled
    tx_idle_pct = 8;
    rx_idle_pct = 60;
    load_sample_stores();
    test_ticks_after_reset();
    test_saturation_extremes();
    test_rewrite_while_playing();
    test_random_phase(17'd37, 17'd12, 17'd5);
    // period of one; an empty subdivision store
    test_random_phase(17'd1, 17'd3, 17'd0);

    // the other way round
    tx_idle_pct = 60;
    rx_idle_pct = 8;
    // zero period, a downbeat length beyond the store with high data bits set, a subdivision length of the whole store
    test_random_phase(17'd0, 17'h1FFFF, 17'd4096);
    test_random_phase(17'h1FFFF, 17'd1, 17'd64);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_phase(17'd100, 17'd20, 17'd30);
    test_output_backpressure();

    frame_mismatches += expected_frames.size();
    if (frame_mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: beat_clip_sample_mixer_top.f
sv/bcsm_pkg.sv
sv/bcsm_sequencer.sv
sv/bcsm_clip_table.sv
sv/bcsm_sample_store.sv
sv/bcsm_mac.sv
sv/beat_clip_sample_mixer_top.sv
bench/tb.sv
